### design/tcm_pkg.sv
`default_nettype none

package tcm_pkg;

    // Register map, indexed by paddr[3:2]
    localparam int          REG_IDX_BITS = 2;
    localparam logic [1:0]  REG_WIDTH    = 2'd0;
    localparam logic [1:0]  REG_HEIGHT   = 2'd1;
    localparam logic [1:0]  REG_ROT      = 2'd2;

    // Rotation codes; anything else takes the default mapping
    localparam int          ROT_BITS = 3;
    localparam logic [2:0]  ROT_0    = 3'd0;
    localparam logic [2:0]  ROT_1    = 3'd1;
    localparam logic [2:0]  ROT_2    = 3'd2;
    localparam logic [2:0]  ROT_3    = 3'd3;

    // Reset values of the configuration registers
    localparam int          RST_WIDTH  = 320;
    localparam int          RST_HEIGHT = 240;
    localparam logic [2:0]  RST_ROT    = ROT_1;

    // Resistive raw window 200..3800; span 3600 = 16 * 225
    localparam int          RAW_LOW   = 200;
    localparam int          RAW_HIGH  = 3800;
    localparam int          DIV_SHIFT = 4;
    localparam int          DIV_ODD   = (RAW_HIGH - RAW_LOW) / (1 << DIV_SHIFT);

endpackage

`default_nettype wire

### design/tcm_cap_map.sv
`default_nettype none

// Capacitive remap: detects a capacitive sample and places the raw point
// by rotation and portrait frame. Values are signed and not yet clamped.
module tcm_cap_map #(
    parameter int COORD_BITS = 12,
    parameter int PIXEL_BITS = 10
) (
    input  wire logic [COORD_BITS-1:0]        i_tx,
    input  wire logic [COORD_BITS-1:0]        i_ty,
    input  wire logic [PIXEL_BITS-1:0]        i_w,
    input  wire logic [PIXEL_BITS-1:0]        i_h,
    input  wire logic [PIXEL_BITS-1:0]        i_wl,
    input  wire logic [PIXEL_BITS-1:0]        i_hl,
    input  wire logic [tcm_pkg::ROT_BITS-1:0] i_rot,
    output logic                              o_is_cap,
    output logic signed [((COORD_BITS > PIXEL_BITS) ? COORD_BITS : PIXEL_BITS)+1:0] o_cx,
    output logic signed [((COORD_BITS > PIXEL_BITS) ? COORD_BITS : PIXEL_BITS)+1:0] o_cy
);

    localparam int EW = ((COORD_BITS > PIXEL_BITS) ? COORD_BITS : PIXEL_BITS) + 2;

    logic signed [EW-1:0] tx, ty, w2, h2, wl, hl;
    logic                 portrait;

    // Widen everything to one signed width
    always_comb begin
        tx = EW'(i_tx);
        ty = EW'(i_ty);
        w2 = EW'(i_w) <<< 1;
        h2 = EW'(i_h) <<< 1;
        wl = EW'(i_wl);
        hl = EW'(i_hl);
    end

    assign o_is_cap = (tx <= w2) && (ty <= h2);
    assign portrait = (tx <= hl) && (ty <= wl);

    // Orientation mapping
    always_comb begin
        if (portrait) begin
            case (i_rot)
                tcm_pkg::ROT_0: begin o_cx = hl - tx; o_cy = ty;      end
                tcm_pkg::ROT_1: begin o_cx = ty;      o_cy = hl - tx; end
                tcm_pkg::ROT_2: begin o_cx = tx;      o_cy = wl - ty; end
                tcm_pkg::ROT_3: begin o_cx = wl - ty; o_cy = tx;      end
                default:        begin o_cx = ty;      o_cy = tx;      end
            endcase
        end else begin
            case (i_rot)
                tcm_pkg::ROT_0: begin o_cx = ty;      o_cy = wl - tx; end
                tcm_pkg::ROT_1: begin o_cx = tx;      o_cy = ty;      end
                tcm_pkg::ROT_2: begin o_cx = hl - ty; o_cy = tx;      end
                tcm_pkg::ROT_3: begin o_cx = wl - tx; o_cy = hl - ty; end
                default:        begin o_cx = tx;      o_cy = ty;      end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/touch_coordinate_mapper.sv
`default_nettype none

// Channel   Dir  Handshake                  Payload (low bit first)
// s (in)    in   i_s_tvalid / o_s_tready    tuser: menu_active, touched
//                                           tdata: raw_x, raw_y, zero pad
// m (out)   out  o_m_tvalid / i_m_tready    tuser: pressed
//                                           tdata: point_x, point_y, zero pad
// cfg       in   psel/penable/pwrite/pready 0x0 width, 0x4 height, 0x8 rotation
//
// Four register stages: map and offset, multiply, reciprocal multiply,
// quotient fix and rotate. One sample per cycle unless the output stalls.
// Each stage takes new data when it is empty or its successor moves, so
// bubbles close up under output backpressure. Synchronous active-low reset
// clears valid bits and loads the register reset values.
module touch_coordinate_mapper #(
    parameter int COORD_BITS = 12,
    parameter int PIXEL_BITS = 10
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // sample input
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,  // raw_x, raw_y
    input  wire logic [1:0]                            i_s_tuser,  // menu_active, touched
    // pixel output
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    output logic [((2*PIXEL_BITS+7)/8)*8-1:0]          o_m_tdata,  // point_x, point_y
    output logic                                       o_m_tuser,  // pressed
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [3:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    localparam int OUT_DW = ((2*PIXEL_BITS+7)/8)*8;
    localparam int EW     = ((COORD_BITS > PIXEL_BITS) ? COORD_BITS : PIXEL_BITS) + 2;
    localparam int PW     = COORD_BITS + PIXEL_BITS;
    localparam int MW     = PW - tcm_pkg::DIV_SHIFT;
    localparam int QW     = MW - 7;
    localparam int XW     = (QW > PIXEL_BITS) ? QW : PIXEL_BITS;
    localparam logic [QW-1:0] RECIP = QW'((1 << MW) / tcm_pkg::DIV_ODD);

    // Configuration registers
    logic [PIXEL_BITS-1:0]        r_width, r_height;
    logic [tcm_pkg::ROT_BITS-1:0] r_rot;
    logic [PIXEL_BITS-1:0]        wl, hl;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= PIXEL_BITS'(tcm_pkg::RST_WIDTH);
            r_height <= PIXEL_BITS'(tcm_pkg::RST_HEIGHT);
            r_rot    <= tcm_pkg::RST_ROT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tcm_pkg::REG_WIDTH:  r_width  <= pwdata[PIXEL_BITS-1:0];
                tcm_pkg::REG_HEIGHT: r_height <= pwdata[PIXEL_BITS-1:0];
                tcm_pkg::REG_ROT:    r_rot    <= pwdata[tcm_pkg::ROT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            tcm_pkg::REG_WIDTH:  prdata = 32'(r_width);
            tcm_pkg::REG_HEIGHT: prdata = 32'(r_height);
            tcm_pkg::REG_ROT:    prdata = 32'(r_rot);
            default:             prdata = 32'd0;
        endcase
    end

    // Landscape sizes
    assign wl = (r_width > r_height) ? r_width : r_height;
    assign hl = (r_width < r_height) ? r_width : r_height;

    // Stage handshake
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4       = !r_v4 || i_m_tready;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_s_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: capacitive map and raw offset
    logic [COORD_BITS-1:0]  tx, ty, raw_lo, n_dx, n_dy;
    logic                   cap;
    logic signed [EW-1:0]   cx, cy;
    logic                   r_p1, r_c1;
    logic signed [EW-1:0]   r_cx1, r_cy1;
    logic [COORD_BITS-1:0]  r_dx1, r_dy1;

    assign tx     = i_s_tdata[COORD_BITS-1:0];
    assign ty     = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign raw_lo = COORD_BITS'(tcm_pkg::RAW_LOW);
    assign n_dx   = (tx >= raw_lo) ? tx - raw_lo : '0;
    assign n_dy   = (ty >= raw_lo) ? ty - raw_lo : '0;

    tcm_cap_map #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_cap_map (
        .i_tx     (tx),
        .i_ty     (ty),
        .i_w      (r_width),
        .i_h      (r_height),
        .i_wl     (wl),
        .i_hl     (hl),
        .i_rot    (r_rot),
        .o_is_cap (cap),
        .o_cx     (cx),
        .o_cy     (cy)
    );

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_p1  <= i_s_tuser[0] && i_s_tuser[1];
            r_c1  <= cap;
            r_cx1 <= cx;
            r_cy1 <= cy;
            r_dx1 <= n_dx;
            r_dy1 <= n_dy;
        end
    end

    // Stage 2: clamp capacitive point, multiply offsets by landscape span
    logic [PIXEL_BITS-1:0]  n_cx2, n_cy2;
    logic                   r_p2, r_c2;
    logic [PIXEL_BITS-1:0]  r_cx2, r_cy2;
    logic [PW-1:0]          r_prx2, r_pry2;

    always_comb begin
        if (r_cx1 < 0 || r_width == '0) begin
            n_cx2 = '0;
        end else if (r_cx1 >= EW'(r_width)) begin
            n_cx2 = r_width - 1'b1;
        end else begin
            n_cx2 = r_cx1[PIXEL_BITS-1:0];
        end
        if (r_cy1 < 0 || r_height == '0) begin
            n_cy2 = '0;
        end else if (r_cy1 >= EW'(r_height)) begin
            n_cy2 = r_height - 1'b1;
        end else begin
            n_cy2 = r_cy1[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_p2   <= r_p1;
            r_c2   <= r_c1;
            r_cx2  <= n_cx2;
            r_cy2  <= n_cy2;
            r_prx2 <= PW'(r_dx1) * PW'(wl);
            r_pry2 <= PW'(r_dy1) * PW'(hl);
        end
    end

    // Stage 3: divide by 16 with a shift, estimate /225 by reciprocal
    logic [MW-1:0]     mx, my;
    logic [MW+QW-1:0]  ex, ey;
    logic              r_p3, r_c3;
    logic [PIXEL_BITS-1:0] r_cx3, r_cy3;
    logic [MW-1:0]     r_mx3, r_my3;
    logic [QW-1:0]     r_qx3, r_qy3;

    assign mx = r_prx2[PW-1:tcm_pkg::DIV_SHIFT];
    assign my = r_pry2[PW-1:tcm_pkg::DIV_SHIFT];
    assign ex = (MW+QW)'(mx) * (MW+QW)'(RECIP);
    assign ey = (MW+QW)'(my) * (MW+QW)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_p3  <= r_p2;
            r_c3  <= r_c2;
            r_cx3 <= r_cx2;
            r_cy3 <= r_cy2;
            r_mx3 <= mx;
            r_my3 <= my;
            r_qx3 <= ex[MW+QW-1:MW];
            r_qy3 <= ey[MW+QW-1:MW];
        end
    end

    // Stage 4: fix quotient by one, clamp to span, rotate, select result
    logic [MW-1:0]          rem_x, rem_y;
    logic [QW-1:0]          qx, qy;
    logic [PIXEL_BITS-1:0]  lx, ly, n_x4, n_y4;
    logic                   r_pr4;
    logic [PIXEL_BITS-1:0]  r_x4, r_y4;

    always_comb begin
        rem_x = r_mx3 - MW'(r_qx3) * MW'(tcm_pkg::DIV_ODD);
        rem_y = r_my3 - MW'(r_qy3) * MW'(tcm_pkg::DIV_ODD);
        qx    = (rem_x >= MW'(tcm_pkg::DIV_ODD)) ? r_qx3 + 1'b1 : r_qx3;
        qy    = (rem_y >= MW'(tcm_pkg::DIV_ODD)) ? r_qy3 + 1'b1 : r_qy3;
        lx    = (XW'(qx) > XW'(wl)) ? wl : PIXEL_BITS'(qx);
        ly    = (XW'(qy) > XW'(hl)) ? hl : PIXEL_BITS'(qy);
    end

    always_comb begin
        if (!r_p3) begin
            n_x4 = '0;
            n_y4 = '0;
        end else if (r_c3) begin
            n_x4 = r_cx3;
            n_y4 = r_cy3;
        end else begin
            case (r_rot)
                tcm_pkg::ROT_0: begin n_x4 = hl - ly; n_y4 = lx;      end
                tcm_pkg::ROT_1: begin n_x4 = lx;      n_y4 = ly;      end
                tcm_pkg::ROT_2: begin n_x4 = ly;      n_y4 = wl - lx; end
                tcm_pkg::ROT_3: begin n_x4 = wl - lx; n_y4 = hl - ly; end
                default:        begin n_x4 = lx;      n_y4 = ly;      end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_pr4 <= r_p3;
            r_x4  <= n_x4;
            r_y4  <= n_y4;
        end
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tuser  = r_pr4;
    assign o_m_tdata  = OUT_DW'({r_y4, r_x4});

`ifndef SYNTHESIS
    // A released result carries a zero point
    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (r_x4 == '0 && r_y4 == '0))
        else $error("released result with nonzero point");

    // Every pressed point lies within the long display side
    a_point_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (r_x4 <= wl && r_y4 <= wl))
        else $error("mapped point beyond landscape width");

    // Input stalls only under output backpressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // An accepted sample occupies the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v1)
        else $error("accepted sample lost at first stage");
`endif

endmodule

`default_nettype wire
